>>> hdl/rhls_pkg.sv
// Types and constants for the RGB to hue/lightness/saturation pixel converter.
// Used by rgb_to_hls_pixel; its pipelined divider rhls_div_pipe does not import it.
package rhls_pkg;

  localparam int CHAN_W      = 8;
  localparam int FULL_SCALE  = (1 << CHAN_W) - 1;
  localparam int HUE_W       = 13;
  localparam int HUE_TURN    = 5760;
  localparam int HUE_SEXTANT = 960;

  // quotient bits of the hue fraction: round(960*(diff+delta)/delta) <= 1920
  localparam int HUE_QB      = 11;
  localparam int DIV_QB      = (CHAN_W > HUE_QB) ? CHAN_W : HUE_QB;

  localparam int SUM_W       = CHAN_W + 1;
  localparam int DEN_W       = CHAN_W + 1;
  localparam int SAT_NUM_W   = 2 * CHAN_W + 1;
  localparam int HUE_NUM_W   = CHAN_W + 12;
  localparam int HUE_SUM_W   = 14;

  // delay from an accepted word to its result strobe
  localparam int LATENCY     = DIV_QB + 3;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rhls_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] lightness;
    logic [CHAN_W-1:0] saturation;
    logic              achromatic;
  } rhls_out_t;

  typedef struct packed {
    max_sel_t          sel;
    logic              gray;
    logic [CHAN_W-1:0] light;
  } rhls_side_t;

endpackage

>>> hdl/rhls_div_pipe.sv
// Pipelined restoring divider: one quotient bit per register stage, Q_W stages.
// Requires num < den * 2**Q_W. Data only; valid bits travel alongside in the caller.
module rhls_div_pipe #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 9,
  parameter int Q_W   = 11
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [Q_W-1:0]   quo_nxt;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] sub_ext;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign rem_ext  = CMP_W'(rem_in);
    assign sub_ext  = CMP_W'(den_in) << (Q_W - 1 - k);
    assign fits     = (rem_ext >= sub_ext);

    always_comb begin
      quo_nxt = quo_in;
      quo_nxt[Q_W-1-k] = fits;
    end

    always_ff @(posedge clk) begin
      quo_r[k] <= quo_nxt;
    end

    if (k < Q_W - 1) begin : g_carry
      logic [CMP_W-1:0] diff_ext;

      assign diff_ext = rem_ext - sub_ext;

      always_ff @(posedge clk) begin
        rem_r[k] <= fits ? diff_ext[NUM_W-1:0] : rem_in;
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

>>> hdl/rgb_to_hls_pixel.sv
// Top level of the RGB to hue/lightness/saturation pixel converter.
// Depends on rhls_pkg and two instances of rhls_div_pipe.
//
// Usage:
//   Input: drive in_word (red, green, blue) and raise start; the word is
//   taken at a rising edge where start is high and busy is low. busy is low
//   in every cycle after reset, so one pixel can enter per clock.
//   Output: out_strobe is high for one cycle with out_word (hue in 1/16
//   degree, lightness, saturation, achromatic). The receiver cannot stall,
//   so nothing holds the pipeline; every word leaves exactly once, in order.
//   Stages: one stage for max/min, one for the divider operands, DIV_QB
//   divider stages (one quotient bit each, saturation and hue dividers
//   side by side), and the output register with the hue wrap.
//   Throughput: one pixel per cycle, set by the one-bit-per-stage dividers.
//   Reset (rst_n low, synchronous): clears all valid bits and holds busy
//   high; words in flight are dropped and no strobe follows them.
module rgb_to_hls_pixel
  import rhls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rhls_in_t  in_word,
  output logic      out_strobe,
  output rhls_out_t out_word
);

  // ---------------------------------------------------------------- stage 1
  logic [CHAN_W-1:0]       ch_r, ch_g, ch_b;
  logic [CHAN_W-1:0]       max_v, min_v;
  max_sel_t                sel_nxt;
  logic signed [CHAN_W:0]  diff_nxt;

  logic                    busy_r;
  logic                    accept;
  logic                    s1_valid_r;
  logic [SUM_W-1:0]        s1_sum_r;
  logic [CHAN_W-1:0]       s1_delta_r;
  logic signed [CHAN_W:0]  s1_diff_r;
  max_sel_t                s1_sel_r;
  logic                    s1_gray_r;

  assign accept = start && !busy_r;

  always_comb begin
    ch_r = in_word.red;
    ch_g = in_word.green;
    ch_b = in_word.blue;
    // ties for the maximum go to red, then green
    priority if (ch_r >= ch_g && ch_r >= ch_b) begin
      sel_nxt  = MAX_RED;
      max_v    = ch_r;
      diff_nxt = $signed({1'b0, ch_g}) - $signed({1'b0, ch_b});
    end else if (ch_g >= ch_b) begin
      sel_nxt  = MAX_GREEN;
      max_v    = ch_g;
      diff_nxt = $signed({1'b0, ch_b}) - $signed({1'b0, ch_r});
    end else begin
      sel_nxt  = MAX_BLUE;
      max_v    = ch_b;
      diff_nxt = $signed({1'b0, ch_r}) - $signed({1'b0, ch_g});
    end
    min_v = (ch_r < ch_g) ? ch_r : ch_g;
    if (ch_b < min_v) begin
      min_v = ch_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      busy_r     <= 1'b0;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_sum_r   <= {1'b0, max_v} + {1'b0, min_v};
    s1_delta_r <= max_v - min_v;
    s1_diff_r  <= diff_nxt;
    s1_sel_r   <= sel_nxt;
    s1_gray_r  <= (max_v == min_v);
  end

  // ---------------------------------------------------------------- stage 2
  logic [SUM_W:0]              light_sum;
  logic [SUM_W-1:0]            far_sum;
  logic [CHAN_W-1:0]           den_v;
  logic signed [CHAN_W+1:0]    span_s;
  logic [CHAN_W:0]             span;
  logic [SAT_NUM_W-1:0]        sat_num_nxt;
  logic [HUE_NUM_W-1:0]        hue_num_nxt;
  rhls_side_t                  side_nxt;

  logic                        s2_valid_r;
  rhls_side_t                  s2_side_r;
  logic [SAT_NUM_W-1:0]        s2_sat_num_r;
  logic [DEN_W-1:0]            s2_sat_den_r;
  logic [HUE_NUM_W-1:0]        s2_hue_num_r;
  logic [DEN_W-1:0]            s2_hue_den_r;

  always_comb begin
    light_sum = {1'b0, s1_sum_r} + (SUM_W+1)'(1);
    far_sum   = SUM_W'(2 * FULL_SCALE) - s1_sum_r;
    den_v     = (s1_sum_r <= SUM_W'(FULL_SCALE)) ? s1_sum_r[CHAN_W-1:0]
                                                 : far_sum[CHAN_W-1:0];
    // 2*FS*delta + den, rounds the saturation quotient half up
    sat_num_nxt = (SAT_NUM_W'(s1_delta_r) << (CHAN_W + 1))
                - (SAT_NUM_W'(s1_delta_r) << 1)
                + SAT_NUM_W'(den_v);
    // bias diff by delta so the hue fraction numerator stays non-negative
    span_s = (CHAN_W+2)'(s1_diff_r) + $signed({2'b00, s1_delta_r});
    span   = span_s[CHAN_W:0];
    hue_num_nxt = HUE_NUM_W'(span) * HUE_NUM_W'(2 * HUE_SEXTANT)
                + HUE_NUM_W'(s1_delta_r);
    side_nxt.sel   = s1_sel_r;
    side_nxt.gray  = s1_gray_r;
    side_nxt.light = light_sum[CHAN_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r    <= side_nxt;
    s2_sat_num_r <= sat_num_nxt;
    s2_sat_den_r <= {den_v, 1'b0};
    s2_hue_num_r <= hue_num_nxt;
    s2_hue_den_r <= {s1_delta_r, 1'b0};
  end

  // --------------------------------------------------------- divider stages
  logic [DIV_QB-1:0] sat_quo;
  logic [DIV_QB-1:0] hue_quo;
  logic [DIV_QB-1:0] valid_line_r;
  rhls_side_t        side_line_r [DIV_QB];

  rhls_div_pipe #(
    .NUM_W (SAT_NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (DIV_QB)
  ) u_sat_div (
    .clk (clk),
    .num (s2_sat_num_r),
    .den (s2_sat_den_r),
    .quo (sat_quo)
  );

  rhls_div_pipe #(
    .NUM_W (HUE_NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (DIV_QB)
  ) u_hue_div (
    .clk (clk),
    .num (s2_hue_num_r),
    .den (s2_hue_den_r),
    .quo (hue_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_line_r <= '0;
    end else begin
      valid_line_r <= {valid_line_r[DIV_QB-2:0], s2_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    side_line_r[0] <= s2_side_r;
    for (int k = 1; k < DIV_QB; k++) begin
      side_line_r[k] <= side_line_r[k-1];
    end
  end

  // ------------------------------------------------------------ output stage
  rhls_side_t           tail;
  logic [HUE_SUM_W-1:0] hue_base;
  logic [HUE_SUM_W-1:0] hue_sum;
  logic [HUE_SUM_W-1:0] hue_wrap;
  rhls_out_t            out_word_nxt;
  logic                 out_strobe_r;
  rhls_out_t            out_word_r;

  always_comb begin
    tail = side_line_r[DIV_QB-1];
    unique case (tail.sel)
      MAX_RED:   hue_base = '0;
      MAX_GREEN: hue_base = HUE_SUM_W'(2 * HUE_SEXTANT);
      MAX_BLUE:  hue_base = HUE_SUM_W'(4 * HUE_SEXTANT);
      default:   hue_base = '0;
    endcase
    // undo the delta bias (one sextant) and add one turn, then wrap once
    hue_sum = hue_base + HUE_SUM_W'(HUE_TURN - HUE_SEXTANT)
            + HUE_SUM_W'(hue_quo[HUE_QB-1:0]);
    hue_wrap = (hue_sum >= HUE_SUM_W'(HUE_TURN)) ? hue_sum - HUE_SUM_W'(HUE_TURN)
                                                 : hue_sum;
    out_word_nxt.hue        = tail.gray ? '0 : hue_wrap[HUE_W-1:0];
    out_word_nxt.lightness  = tail.light;
    out_word_nxt.saturation = tail.gray ? '0 : sat_quo[CHAN_W-1:0];
    out_word_nxt.achromatic = tail.gray;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= valid_line_r[DIV_QB-1];
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // -------------------------------------------------------------- assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(LATENCY) out_strobe)
    else $error("accepted word did not produce a strobe after the pipeline latency");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_word.hue < HUE_W'(HUE_TURN))
    else $error("hue left the range of one turn");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.achromatic |-> out_word.hue == '0 && out_word.saturation == '0)
    else $error("gray pixel with nonzero hue or saturation");

  a_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.achromatic |-> out_word.saturation != '0)
    else $error("colored pixel with zero saturation");

endmodule
